[sv/hte_pkg.sv]
// ----------------------------------------------------------------------------
// hte_pkg
// Shared types and codes for the table-driven Huffman encoder.
// ----------------------------------------------------------------------------
package hte_pkg;

  localparam int BYTE_W = 8;

  // request codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  // result status codes
  localparam logic STATUS_DATA   = 1'b0;
  localparam logic STATUS_NOCODE = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  symbol;
    logic [31:0] code_bits;
    logic [5:0]  code_len;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              status;
    logic              last;
  } out_item_t;

endpackage

[sv/hte_table.sv]
// ----------------------------------------------------------------------------
// hte_table
// 256-entry code table: one write port and one registered read port.
// ----------------------------------------------------------------------------
module hte_table import hte_pkg::*; #(
  parameter int MAX_CODE_LEN = 32,
  localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1),
  localparam int WORD_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic              rd_en_i,
  input  logic [7:0]        addr_i,
  input  logic [31:0]       code_bits_i,
  input  logic [5:0]        code_len_i,
  output logic [LEN_W-1:0]  len_o,
  output logic [WORD_W-1:0] word_o
);

  logic [LEN_W+WORD_W-1:0] mem_q [256];
  logic [LEN_W+WORD_W-1:0] rd_q;
  logic [255:0]            vld_q;
  logic                    rd_vld_q;
  logic [LEN_W-1:0]        len_sat;
  logic [WORD_W-1:0]       word_msk;

  // saturate the length, drop code bits above it
  always_comb begin
    if (code_len_i > 6'(MAX_CODE_LEN)) begin
      len_sat = LEN_W'(MAX_CODE_LEN);
    end else begin
      len_sat = LEN_W'(code_len_i);
    end
    for (int b = 0; b < WORD_W; b++) begin
      word_msk[b] = code_bits_i[b] & (b < int'(len_sat));
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= {len_sat, word_msk};
    end
    if (rd_en_i) begin
      rd_q <= mem_q[addr_i];
    end
  end

  // entries never written read as no code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[addr_i];
      end
    end
  end

  assign len_o  = rd_vld_q ? rd_q[LEN_W+WORD_W-1:WORD_W] : '0;
  assign word_o = rd_vld_q ? rd_q[WORD_W-1:0] : '0;

endmodule

[sv/hte_packer.sv]
// ----------------------------------------------------------------------------
// hte_packer
// MSB-first bit packer; the result register drains one byte a cycle on out_ready_i.
// ----------------------------------------------------------------------------
module hte_packer import hte_pkg::*; #(
  parameter int MAX_CODE_LEN = 32,
  localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1),
  localparam int WORD_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  logic [1:0]        item_req_i,
  input  logic [LEN_W-1:0]  code_len_i,
  input  logic [WORD_W-1:0] code_word_i,
  output logic              item_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_o
);

  localparam int ACC_W   = MAX_CODE_LEN + 7;
  localparam int TOT_W   = $clog2(ACC_W + 1);
  localparam int MAX_OUT = (MAX_CODE_LEN + 7) / BYTE_W;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  logic [6:0]        pend_bits_q, pend_bits_d;
  logic [2:0]        pend_cnt_q, pend_cnt_d;
  logic              grp_vld_q, grp_vld_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic              status_q, status_d;
  logic [BYTE_W-1:0] bytes_q [MAX_OUT];
  logic [BYTE_W-1:0] bytes_d [MAX_OUT];

  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  aligned;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  shamt;
  logic [6:0]        keep_mask;
  logic [BYTE_W-1:0] flush_byte;
  logic              is_enc, is_flush, no_code;
  logic              produce, grp_free, take, out_xfer;

  always_comb begin
    acc        = (ACC_W'(pend_bits_q) << code_len_i) | ACC_W'(code_word_i);
    total      = TOT_W'(pend_cnt_q) + TOT_W'(code_len_i);
    shamt      = TOT_W'(ACC_W) - total;
    // first pending bit lands in the top bit
    aligned    = acc << shamt;
    keep_mask  = 7'((8'd1 << total[2:0]) - 8'd1);
    flush_byte = BYTE_W'({1'b0, pend_bits_q} << (4'd8 - {1'b0, pend_cnt_q}));
  end

  assign is_enc   = item_req_i == REQ_ENCODE;
  assign is_flush = item_req_i == REQ_FLUSH;
  assign no_code  = code_len_i == '0;
  assign produce  = (is_enc && (no_code || total >= TOT_W'(BYTE_W)))
                 || (is_flush && pend_cnt_q != 3'd0);
  assign out_xfer = grp_vld_q && out_ready_i;
  assign grp_free = !grp_vld_q || (out_ready_i && rem_q == CNT_W'(1));
  assign item_ready_o = grp_free || !produce;
  assign take     = item_valid_i && item_ready_o;

  always_comb begin
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    if (take && is_enc && !no_code) begin
      pend_bits_d = acc[6:0] & keep_mask;
      pend_cnt_d  = total[2:0];
    end else if (take && is_flush) begin
      pend_bits_d = '0;
      pend_cnt_d  = '0;
    end
  end

  always_comb begin
    grp_vld_d = grp_vld_q;
    rem_d     = rem_q;
    status_d  = status_q;
    bytes_d   = bytes_q;
    if (take && produce) begin
      grp_vld_d = 1'b1;
      status_d  = STATUS_DATA;
      rem_d     = CNT_W'(1);
      if (is_enc && no_code) begin
        status_d   = STATUS_NOCODE;
        bytes_d[0] = '0;
      end else if (is_flush) begin
        bytes_d[0] = flush_byte;
      end else begin
        rem_d = CNT_W'(total >> 3);
        for (int k = 0; k < MAX_OUT; k++) begin
          bytes_d[k] = aligned[ACC_W-1-BYTE_W*k -: BYTE_W];
        end
      end
    end else if (out_xfer) begin
      // shift the next byte to the head
      rem_d     = rem_q - CNT_W'(1);
      grp_vld_d = rem_q != CNT_W'(1);
      for (int k = 0; k < MAX_OUT - 1; k++) begin
        bytes_d[k] = bytes_q[k+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      grp_vld_q   <= 1'b0;
      rem_q       <= '0;
      status_q    <= STATUS_DATA;
    end else begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      grp_vld_q   <= grp_vld_d;
      rem_q       <= rem_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  assign out_valid_o    = grp_vld_q;
  assign out_o.out_byte = bytes_q[0];
  assign out_o.status   = status_q;
  assign out_o.last     = rem_q == CNT_W'(1);

endmodule

[sv/huffman_table_encoder.sv]
// ----------------------------------------------------------------------------
// huffman_table_encoder
// Table-driven Huffman encoder: code table lookup feeding an MSB-first packer.
// ----------------------------------------------------------------------------
// Pipeline: an item's table entry is read at its transfer edge; its first
//   result is packed into the result register once the packer takes the item.
// Throughput: one item per cycle while each item gives at most one result and
//   the output is ready; a k-byte item keeps the byte port until all k drain.
// Reset: clears the table valid bits (every symbol reads as no code), the
//   packer's pending bits and all pipeline valids; no clearing pass is needed.
module huffman_table_encoder import hte_pkg::*; #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_o
);

  localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
  localparam int WORD_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;

  logic              s1_valid_q;
  logic [1:0]        s1_req_q;
  logic              s1_ready;
  logic              in_xfer;
  logic [LEN_W-1:0]  rd_len;
  logic [WORD_W-1:0] rd_word;

  assign in_ready_o = !s1_valid_q || s1_ready;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_req_q   <= REQ_LOAD;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
      s1_req_q   <= in_i.req_type;
    end
  end

  hte_table #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (in_xfer && in_i.req_type == REQ_LOAD),
    .rd_en_i    (in_xfer),
    .addr_i     (in_i.symbol),
    .code_bits_i(in_i.code_bits),
    .code_len_i (in_i.code_len),
    .len_o      (rd_len),
    .word_o     (rd_word)
  );

  hte_packer #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(s1_valid_q),
    .item_req_i  (s1_req_q),
    .code_len_i  (rd_len),
    .code_word_i (rd_word),
    .item_ready_o(s1_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // a no-code result stands alone with a zero byte
  a_nocode_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == STATUS_NOCODE |-> out_o.last && out_o.out_byte == '0)
    else $error("no-code result not a single zero byte");

  // an item held in the lookup stage is not lost while it waits
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_ready |=> s1_valid_q && $stable(s1_req_q))
    else $error("lookup stage item dropped while stalled");

  // a stalled result group keeps its head byte
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

endmodule
